// ===== sv/rlpe_pkg.sv =====
package rlpe_pkg;

    localparam int CHAN_W    = 8;
    localparam int PCT_W     = 7;
    localparam int SHORT_W   = 16;
    localparam int LONG_W    = 20;
    localparam int LED_BITS  = 24;
    localparam int CNT_W     = 5;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690;
    // x = chan * pct never exceeds 25500
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int K_W         = 20;
    localparam int PCT_MAX     = 100;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BRIGHT    = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [2:0] REG_ONE_LOW   = 3'd4;
    localparam logic [2:0] REG_LATCH_LOW = 3'd5;

    typedef struct packed {
        logic [SHORT_W-1:0] zero_high;
        logic [SHORT_W-1:0] zero_low;
        logic [SHORT_W-1:0] one_high;
        logic [SHORT_W-1:0] one_low;
        logic [LONG_W-1:0]  latch_low;
    } t_timing;

    // brightness factor pre-multiplied by the reciprocal of 100, saturated
    function automatic logic [K_W-1:0] pct_factor(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] sat;
        sat = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
        return K_W'(sat) * K_W'(RECIP_100);
    endfunction

endpackage

// ===== sv/rgb_led_pulse_encoder.sv =====
// channel | direction | handshake         | beat
// input   | in        | i_valid / o_stall | i_red, i_green, i_blue, i_last_led
// output  | out       | o_valid / i_stall | o_high_time, o_low_time, o_bit_value,
//         |           |                   | o_last_of_run
// config  | in        | APB write/read    | psel, penable, pwrite, paddr, pwdata
//
// One output beat per cycle while i_stall is low: an LED gives 24 beats (25 with
// the latch gap), and the serializer shift register paces the LEDs.
// An input beat passes through the lane multiply register and then the serializer load.
// A staged LED waits in the lane registers while the serializer drains the
// previous one. Reset is synchronous, active low, and restores the timing
// defaults; i_stall holds the current output beat.
module rgb_led_pulse_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlpe_pkg::ADDR_W-1:0]   paddr,
    input  logic [rlpe_pkg::DATA_W-1:0]   pwdata,
    output logic [rlpe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_red,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_green,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_blue,
    input  logic                          i_last_led,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rlpe_pkg::SHORT_W-1:0]  o_high_time,
    output logic [rlpe_pkg::LONG_W-1:0]   o_low_time,
    output logic                          o_bit_value,
    output logic                          o_last_of_run
);
    import rlpe_pkg::*;

    logic [PCT_W-1:0]   r_bright;
    logic [K_W-1:0]     r_factor;
    t_timing            r_tm;

    logic               r_s_valid, n_s_valid;
    logic               r_s_last;

    logic               wr;
    logic [2:0]         reg_idx;
    logic               in_acc;
    logic               load;
    logic               ser_free;
    logic [CHAN_W-1:0]  sc_red, sc_green, sc_blue;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright     <= PCT_W'(PCT_MAX);
            r_factor     <= pct_factor(PCT_W'(PCT_MAX));
            r_tm.zero_high <= SHORT_W'(30);
            r_tm.zero_low  <= SHORT_W'(90);
            r_tm.one_high  <= SHORT_W'(60);
            r_tm.one_low   <= SHORT_W'(60);
            r_tm.latch_low <= LONG_W'(7980);
        end else if (wr) begin
            unique case (reg_idx)
                REG_BRIGHT: begin
                    r_bright <= pwdata[PCT_W-1:0];
                    r_factor <= pct_factor(pwdata[PCT_W-1:0]);
                end
                REG_ZERO_HIGH: r_tm.zero_high <= pwdata[SHORT_W-1:0];
                REG_ZERO_LOW:  r_tm.zero_low  <= pwdata[SHORT_W-1:0];
                REG_ONE_HIGH:  r_tm.one_high  <= pwdata[SHORT_W-1:0];
                REG_ONE_LOW:   r_tm.one_low   <= pwdata[SHORT_W-1:0];
                REG_LATCH_LOW: r_tm.latch_low <= pwdata[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BRIGHT:    prdata = DATA_W'(r_bright);
            REG_ZERO_HIGH: prdata = DATA_W'(r_tm.zero_high);
            REG_ZERO_LOW:  prdata = DATA_W'(r_tm.zero_low);
            REG_ONE_HIGH:  prdata = DATA_W'(r_tm.one_high);
            REG_ONE_LOW:   prdata = DATA_W'(r_tm.one_low);
            REG_LATCH_LOW: prdata = DATA_W'(r_tm.latch_low);
            default:       prdata = '0;
        endcase
    end

    // lane stage: one slot, drained when the serializer loads
    assign load    = r_s_valid && ser_free;
    assign o_stall = r_s_valid && !ser_free;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_s_valid = r_s_valid;
        if (load) begin
            n_s_valid = 1'b0;
        end
        if (in_acc) begin
            n_s_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s_last <= i_last_led;
        end
    end

    rlpe_lane u_lane_red (
        .i_clk    (i_clk),
        .i_en     (in_acc),
        .i_chan   (i_red),
        .i_factor (r_factor),
        .o_scaled (sc_red)
    );

    rlpe_lane u_lane_green (
        .i_clk    (i_clk),
        .i_en     (in_acc),
        .i_chan   (i_green),
        .i_factor (r_factor),
        .o_scaled (sc_green)
    );

    rlpe_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (in_acc),
        .i_chan   (i_blue),
        .i_factor (r_factor),
        .o_scaled (sc_blue)
    );

    rlpe_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_red         (sc_red),
        .i_green       (sc_green),
        .i_blue        (sc_blue),
        .i_last        (r_s_last),
        .i_tm          (r_tm),
        .i_stall       (i_stall),
        .o_free        (ser_free),
        .o_valid       (o_valid),
        .o_high_time   (o_high_time),
        .o_low_time    (o_low_time),
        .o_bit_value   (o_bit_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== sv/rlpe_lane.sv =====
module rlpe_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rlpe_pkg::CHAN_W-1:0]  i_chan,
    input  logic [rlpe_pkg::K_W-1:0]     i_factor,
    output logic [rlpe_pkg::CHAN_W-1:0]  o_scaled
);
    import rlpe_pkg::*;

    localparam int PROD_W = CHAN_W + K_W;

    logic [PROD_W-1:0]  prod;
    logic [CHAN_W-1:0]  r_scaled;

    assign prod = PROD_W'(i_chan) * PROD_W'(i_factor);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= prod[RECIP_SHIFT +: CHAN_W];
        end
    end

    assign o_scaled = r_scaled;

endmodule

// ===== sv/rlpe_serializer.sv =====
module rlpe_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_red,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_green,
    input  logic [rlpe_pkg::CHAN_W-1:0]   i_blue,
    input  logic                          i_last,
    input  rlpe_pkg::t_timing             i_tm,
    input  logic                          i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output logic [rlpe_pkg::SHORT_W-1:0]  o_high_time,
    output logic [rlpe_pkg::LONG_W-1:0]   o_low_time,
    output logic                          o_bit_value,
    output logic                          o_last_of_run
);
    import rlpe_pkg::*;

    logic                r_busy, n_busy;
    logic [LED_BITS-1:0] r_word, n_word;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_last, n_last;

    logic latch_beat;
    logic fin;
    logic out_acc;

    assign latch_beat = (r_cnt == CNT_W'(LED_BITS));
    assign fin        = latch_beat || ((r_cnt == CNT_W'(LED_BITS - 1)) && !r_last);
    assign out_acc    = r_busy && !i_stall;
    assign o_free     = !r_busy || (out_acc && fin);

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (out_acc) begin
            n_word = {r_word[LED_BITS-2:0], 1'b0};
            n_cnt  = r_cnt + CNT_W'(1);
            if (fin) begin
                n_busy = 1'b0;
            end
        end
        // green, red, blue order, msb first
        if (i_load) begin
            n_busy = 1'b1;
            n_word = {i_green, i_red, i_blue};
            n_cnt  = '0;
            n_last = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_last <= n_last;
    end

    always_comb begin
        if (latch_beat) begin
            o_high_time = '0;
            o_low_time  = i_tm.latch_low;
            o_bit_value = 1'b0;
        end else if (r_word[LED_BITS-1]) begin
            o_high_time = i_tm.one_high;
            o_low_time  = LONG_W'(i_tm.one_low);
            o_bit_value = 1'b1;
        end else begin
            o_high_time = i_tm.zero_high;
            o_low_time  = LONG_W'(i_tm.zero_low);
            o_bit_value = 1'b0;
        end
    end

    assign o_valid       = r_busy;
    assign o_last_of_run = fin;

endmodule

// ===== sv/rlpe_checker.sv =====
module rlpe_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [rlpe_pkg::SHORT_W-1:0]  o_high_time,
    input  logic [rlpe_pkg::LONG_W-1:0]   o_low_time,
    input  logic                          o_bit_value,
    input  logic                          o_last_of_run
);
    import rlpe_pkg::*;

    logic             out_acc;
    logic [CNT_W-1:0] r_beats;

    assign out_acc = o_valid && !i_stall;

    // beat position inside the current LED's run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= '0;
        end else if (out_acc) begin
            r_beats <= o_last_of_run ? '0 : r_beats + CNT_W'(1);
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_high_time, o_low_time, o_bit_value, o_last_of_run}))
        else $error("output beat changed while stalled");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_last_of_run |->
            (r_beats == CNT_W'(LED_BITS - 1)) || (r_beats == CNT_W'(LED_BITS)))
        else $error("run ended at wrong beat count");

    a_latch_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_beats == CNT_W'(LED_BITS)) |->
            o_last_of_run && (o_high_time == '0) && !o_bit_value)
        else $error("latch gap beat malformed");

endmodule

bind rgb_led_pulse_encoder rlpe_checker u_rlpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_high_time   (o_high_time),
    .o_low_time    (o_low_time),
    .o_bit_value   (o_bit_value),
    .o_last_of_run (o_last_of_run)
);
